// ----- design/rgbf_pkg.sv -----
package rgbf_pkg;

    localparam int RATE_FRAC_BITS = 16;
    localparam int PWM_SCALE      = 10;

    localparam int COLOR_W    = 8;
    localparam int FADE_W     = 16;
    localparam int CNT_W      = FADE_W + 1;
    localparam int OUT_W      = 12;
    localparam int DIVIDEND_W = COLOR_W + RATE_FRAC_BITS;
    localparam int RATE_W     = DIVIDEND_W + 1;
    localparam int PROD_W     = RATE_W + CNT_W + 1;
    localparam int STEP_W     = PROD_W - RATE_FRAC_BITS;
    localparam int SUM_W      = STEP_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    localparam int NUM_CH     = 3;
    localparam int CH_W       = 2;

    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [0:0] REG_FADE_MS = 1'b0;

    localparam logic [0:0] KIND_COLOR = 1'b0;
    localparam logic [0:0] KIND_TICK  = 1'b1;

    localparam logic [COLOR_W-1:0] LEVEL_MAX = {COLOR_W{1'b1}};

endpackage

// ----- design/rgb_linear_fade.sv -----
// Tick beat while fading: S_MUL registers each channel's product and S_ADD its level, one
// channel after another, then S_DONE. Tick beat once the fade is over or the fade time is zero:
// straight to S_DONE. Colour beat with a nonzero fade time: the shared bit-serial divider
// computes the three channel rates one after another; zero fade time: targets only. New beats
// are taken in S_IDLE; a finished result may wait in the output register while one is accepted.
// Synchronous active-low reset clears the fade time, target and start colours, rates, count and output valid.
module rgb_linear_fade (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic [rgbf_pkg::COLOR_W-1:0]        i_red,
    input  logic [rgbf_pkg::COLOR_W-1:0]        i_green,
    input  logic [rgbf_pkg::COLOR_W-1:0]        i_blue,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rgbf_pkg::OUT_W-1:0]          o_red_compare,
    output logic [rgbf_pkg::OUT_W-1:0]          o_green_compare,
    output logic [rgbf_pkg::OUT_W-1:0]          o_blue_compare,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgbf_pkg::ADDR_W-1:0]         paddr,
    input  logic [rgbf_pkg::DATA_W-1:0]         pwdata,
    output logic [rgbf_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DIV_GO   = 3'd1;
    localparam logic [2:0] S_DIV_WAIT = 3'd2;
    localparam logic [2:0] S_MUL      = 3'd3;
    localparam logic [2:0] S_ADD      = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    localparam logic [rgbf_pkg::CH_W-1:0] CH_LAST = rgbf_pkg::CH_W'(rgbf_pkg::NUM_CH - 1);

    logic [2:0]                             r_state;
    logic [rgbf_pkg::CH_W-1:0]              r_ch;
    logic [rgbf_pkg::FADE_W-1:0]            r_fade;
    logic [rgbf_pkg::CNT_W-1:0]             r_elapsed;
    logic [rgbf_pkg::COLOR_W-1:0]           r_target [rgbf_pkg::NUM_CH];
    logic [rgbf_pkg::COLOR_W-1:0]           r_start  [rgbf_pkg::NUM_CH];
    logic signed [rgbf_pkg::RATE_W-1:0]     r_rate   [rgbf_pkg::NUM_CH];
    logic [rgbf_pkg::COLOR_W-1:0]           r_lvl    [rgbf_pkg::NUM_CH];
    logic signed [rgbf_pkg::PROD_W-1:0]     r_prod;

    logic                                   n_accept;
    logic                                   n_cfg_wr;
    logic                                   n_fading;
    logic                                   n_out_load;
    logic [rgbf_pkg::COLOR_W:0]             n_diff;
    logic [rgbf_pkg::COLOR_W:0]             n_mag;
    logic [rgbf_pkg::DIVIDEND_W-1:0]        n_dividend;
    logic [rgbf_pkg::DIVIDEND_W-1:0]        n_quotient;
    logic signed [rgbf_pkg::RATE_W-1:0]     n_quo_s;
    logic signed [rgbf_pkg::PROD_W-1:0]     n_prod;
    logic signed [rgbf_pkg::PROD_W-1:0]     n_prod_sh;
    logic signed [rgbf_pkg::STEP_W-1:0]     n_step;
    logic signed [rgbf_pkg::SUM_W-1:0]      n_sum;
    logic [rgbf_pkg::COLOR_W-1:0]           n_level;
    logic                                   n_div_start;
    logic                                   n_div_done;

    assign o_in_ready = (r_state == S_IDLE);
    assign n_accept   = i_in_valid && o_in_ready;
    assign pready     = 1'b1;
    assign n_cfg_wr   = psel && penable && pwrite && pready
                        && (paddr[rgbf_pkg::ADDR_W-1] == rgbf_pkg::REG_FADE_MS);
    assign prdata     = (paddr[rgbf_pkg::ADDR_W-1] == rgbf_pkg::REG_FADE_MS)
                        ? rgbf_pkg::DATA_W'(r_fade) : '0;
    assign n_fading   = (r_fade != '0)
                        && (r_elapsed <= rgbf_pkg::CNT_W'(r_fade));
    assign n_out_load = (r_state == S_DONE) && (!o_out_valid || i_out_ready);

    always_comb begin
        n_diff     = {1'b0, r_target[r_ch]} - {1'b0, r_start[r_ch]};
        n_mag      = n_diff[rgbf_pkg::COLOR_W] ? (~n_diff + 1'b1) : n_diff;
        n_dividend = {n_mag[rgbf_pkg::COLOR_W-1:0], {rgbf_pkg::RATE_FRAC_BITS{1'b0}}};
        n_quo_s    = $signed({1'b0, n_quotient});
        n_prod     = r_rate[r_ch] * $signed({1'b0, r_elapsed});
        n_prod_sh  = r_prod >>> rgbf_pkg::RATE_FRAC_BITS;
        n_step     = n_prod_sh[rgbf_pkg::STEP_W-1:0];
        n_sum      = $signed(rgbf_pkg::SUM_W'({1'b0, r_start[r_ch]}))
                     + rgbf_pkg::SUM_W'(n_step);
        if (n_sum < 0) begin
            n_level = '0;
        end else if (n_sum > rgbf_pkg::SUM_W'(rgbf_pkg::LEVEL_MAX)) begin
            n_level = rgbf_pkg::LEVEL_MAX;
        end else begin
            n_level = n_sum[rgbf_pkg::COLOR_W-1:0];
        end
        n_div_start = (r_state == S_DIV_GO);
    end

    rgbf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (r_fade),
        .o_done     (n_div_done),
        .o_quotient (n_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_fade      <= '0;
            r_elapsed   <= '0;
            r_target    <= '{default: '0};
            r_start     <= '{default: '0};
            r_rate      <= '{default: '0};
            o_out_valid <= 1'b0;
        end else begin
            if (n_cfg_wr) begin
                r_fade <= pwdata[rgbf_pkg::FADE_W-1:0];
            end
            if (n_out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_ch <= '0;
                        if (i_kind == rgbf_pkg::KIND_COLOR) begin
                            r_start     <= r_target;
                            r_target[0] <= i_red;
                            r_target[1] <= i_green;
                            r_target[2] <= i_blue;
                            if (r_fade != '0) begin
                                r_elapsed <= '0;
                                r_state   <= S_DIV_GO;
                            end
                        end else if (n_fading) begin
                            r_state <= S_MUL;
                        end else begin
                            r_lvl   <= r_target;
                            r_start <= r_target;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (n_div_done) begin
                        r_rate[r_ch] <= n_diff[rgbf_pkg::COLOR_W] ? -n_quo_s : n_quo_s;
                        if (r_ch == CH_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_lvl[r_ch] <= n_level;
                    if (r_ch == CH_LAST) begin
                        r_elapsed <= r_elapsed + 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (n_out_load) begin
                        o_red_compare   <= rgbf_pkg::OUT_W'(r_lvl[0])
                                           * rgbf_pkg::OUT_W'(rgbf_pkg::PWM_SCALE);
                        o_green_compare <= rgbf_pkg::OUT_W'(r_lvl[1])
                                           * rgbf_pkg::OUT_W'(rgbf_pkg::PWM_SCALE);
                        o_blue_compare  <= rgbf_pkg::OUT_W'(r_lvl[2])
                                           * rgbf_pkg::OUT_W'(rgbf_pkg::PWM_SCALE);
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside the finishing step");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider result arrived while not waiting for it");

    a_channel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch <= CH_LAST)
        else $error("channel index out of range");

    a_elapsed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elapsed <= rgbf_pkg::CNT_W'({rgbf_pkg::FADE_W{1'b1}}) + 1'b1)
        else $error("elapsed count beyond the longest fade");

endmodule

// ----- design/rgbf_div.sv -----
module rgbf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [rgbf_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [rgbf_pkg::FADE_W-1:0]         i_divisor,
    output logic                                o_done,
    output logic [rgbf_pkg::DIVIDEND_W-1:0]     o_quotient
);

    // Restoring divider that retires one quotient bit per cycle.
    logic                               r_busy;
    logic                               r_done;
    logic [rgbf_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [rgbf_pkg::FADE_W-1:0]        r_rem;
    logic [rgbf_pkg::DIVIDEND_W-1:0]    r_quo;

    logic [rgbf_pkg::FADE_W:0]          n_rem_sh;
    logic                               n_ge;
    logic [rgbf_pkg::FADE_W:0]          n_diff;
    logic [rgbf_pkg::FADE_W-1:0]        n_rem;
    logic [rgbf_pkg::DIVIDEND_W-1:0]    n_quo;

    always_comb begin
        n_rem_sh = {r_rem, r_quo[rgbf_pkg::DIVIDEND_W-1]};
        n_ge     = (n_rem_sh >= {1'b0, i_divisor});
        n_diff   = n_rem_sh - {1'b0, i_divisor};
        n_rem    = n_ge ? n_diff[rgbf_pkg::FADE_W-1:0] : n_rem_sh[rgbf_pkg::FADE_W-1:0];
        n_quo    = {r_quo[rgbf_pkg::DIVIDEND_W-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rgbf_pkg::DIV_CNT_W'(rgbf_pkg::DIVIDEND_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rgbf_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0) && (r_cnt <= rgbf_pkg::DIV_CNT_W'(rgbf_pkg::DIVIDEND_W)))
        else $error("divider step count out of range");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider restarted while busy");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_WAIT  = 120;
    localparam int SINK_HOLD    = 400;
    localparam int RANDOM_BEATS = 800;

    typedef struct packed {
        logic [0:0]                   kind;
        logic [rgbf_pkg::COLOR_W-1:0] red;
        logic [rgbf_pkg::COLOR_W-1:0] green;
        logic [rgbf_pkg::COLOR_W-1:0] blue;
    } t_fade_beat;

    typedef struct packed {
        logic [rgbf_pkg::OUT_W-1:0] red;
        logic [rgbf_pkg::OUT_W-1:0] green;
        logic [rgbf_pkg::OUT_W-1:0] blue;
    } t_compare;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid  = 1'b0;
    t_fade_beat on_wire   = '0;
    logic       out_ready = 1'b0;

    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [rgbf_pkg::ADDR_W-1:0] paddr   = '0;
    logic [rgbf_pkg::DATA_W-1:0] pwdata  = '0;

    logic                        in_ready;
    logic                        out_valid;
    logic [rgbf_pkg::OUT_W-1:0]  red_cmp;
    logic [rgbf_pkg::OUT_W-1:0]  green_cmp;
    logic [rgbf_pkg::OUT_W-1:0]  blue_cmp;
    logic [rgbf_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    t_fade_beat beats_to_send [$];
    t_compare   compare_due [$];

    int mdl_fade;
    int mdl_target [rgbf_pkg::NUM_CH];
    int mdl_start [rgbf_pkg::NUM_CH];
    int mdl_rate [rgbf_pkg::NUM_CH];
    int mdl_elapsed;

    int errors        = 0;
    int beats_queued  = 0;
    int beats_taken   = 0;
    int ticks_taken   = 0;
    int results_seen  = 0;
    int fade_settings = 0;
    int stall_cycles  = 0;

    bit sink_pause_req  = 1'b0;
    bit sink_pause_done = 1'b0;
    int sink_hold       = 0;
    int src_cycle       = 0;
    int sink_cycle      = 0;

    rgb_linear_fade dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (on_wire.kind),
        .i_red           (on_wire.red),
        .i_green         (on_wire.green),
        .i_blue          (on_wire.blue),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_red_compare   (red_cmp),
        .o_green_compare (green_cmp),
        .o_blue_compare  (blue_cmp),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("tb: %s", msg);
        end
    endfunction

    function automatic void fade_model_step(input t_fade_beat b);
        int       col [rgbf_pkg::NUM_CH];
        int       lvl [rgbf_pkg::NUM_CH];
        int       diff;
        int       mag;
        int       quot;
        longint   prod;
        t_compare due;
        col[0] = b.red;
        col[1] = b.green;
        col[2] = b.blue;
        if (b.kind == rgbf_pkg::KIND_COLOR) begin
            for (int i = 0; i < rgbf_pkg::NUM_CH; i++) begin
                mdl_start[i]  = mdl_target[i];
                mdl_target[i] = col[i];
            end
            if (mdl_fade != 0) begin
                mdl_elapsed = 0;
                for (int i = 0; i < rgbf_pkg::NUM_CH; i++) begin
                    diff = mdl_target[i] - mdl_start[i];
                    mag  = (diff < 0) ? -diff : diff;
                    quot = (mag << rgbf_pkg::RATE_FRAC_BITS) / mdl_fade;
                    mdl_rate[i] = (diff < 0) ? -quot : quot;
                end
            end
        end else begin
            if (mdl_fade != 0 && mdl_elapsed <= mdl_fade) begin
                for (int i = 0; i < rgbf_pkg::NUM_CH; i++) begin
                    prod   = longint'(mdl_rate[i]) * longint'(mdl_elapsed);
                    lvl[i] = mdl_start[i] + int'(prod >>> rgbf_pkg::RATE_FRAC_BITS);
                    if (lvl[i] < 0) lvl[i] = 0;
                    if (lvl[i] > int'(rgbf_pkg::LEVEL_MAX)) lvl[i] = int'(rgbf_pkg::LEVEL_MAX);
                end
                mdl_elapsed = (mdl_elapsed + 1) & ((1 << rgbf_pkg::CNT_W) - 1);
            end else begin
                for (int i = 0; i < rgbf_pkg::NUM_CH; i++) begin
                    lvl[i]       = mdl_target[i];
                    mdl_start[i] = mdl_target[i];
                end
            end
            due.red   = rgbf_pkg::OUT_W'(lvl[0] * rgbf_pkg::PWM_SCALE);
            due.green = rgbf_pkg::OUT_W'(lvl[1] * rgbf_pkg::PWM_SCALE);
            due.blue  = rgbf_pkg::OUT_W'(lvl[2] * rgbf_pkg::PWM_SCALE);
            compare_due.push_back(due);
        end
    endfunction

    always @(posedge i_clk) begin
        t_fade_beat nb;
        src_cycle++;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                fade_model_step(on_wire);
                beats_taken++;
                if (on_wire.kind == rgbf_pkg::KIND_TICK) ticks_taken++;
            end
            if (!in_valid || in_ready) begin
                if (beats_to_send.size() > 0 &&
                    !((src_cycle % 3000) >= 900 && $urandom_range(0, 99) < 10)) begin
                    nb = beats_to_send.pop_front();
                    on_wire  <= nb;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_compare want;
        sink_cycle++;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (compare_due.size() == 0) begin
                    flag_error($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                         red_cmp, green_cmp, blue_cmp));
                end else begin
                    want = compare_due.pop_front();
                    if (want.red !== red_cmp || want.green !== green_cmp ||
                        want.blue !== blue_cmp) begin
                        flag_error($sformatf(
                            "result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                            results_seen, want.red, want.green, want.blue,
                            red_cmp, green_cmp, blue_cmp));
                    end
                end
            end
            if (sink_pause_req && !sink_pause_done) begin
                sink_hold       = SINK_HOLD;
                sink_pause_done = 1'b1;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !((sink_cycle % 2600) >= 700 && $urandom_range(0, 99) < 10);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: watchdog expired after %0d idle cycles", stall_cycles);
            $display("tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_beat(input logic [0:0] kind, input int r, input int g, input int b);
        t_fade_beat nb;
        nb.kind  = kind;
        nb.red   = rgbf_pkg::COLOR_W'(r);
        nb.green = rgbf_pkg::COLOR_W'(g);
        nb.blue  = rgbf_pkg::COLOR_W'(b);
        beats_to_send.push_back(nb);
        beats_queued++;
    endtask

    task automatic push_color(input int r, input int g, input int b);
        push_beat(rgbf_pkg::KIND_COLOR, r, g, b);
    endtask

    task automatic push_ticks(input int count);
        repeat (count) begin
            push_beat(rgbf_pkg::KIND_TICK, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
        end
    endtask

    task automatic drain_all();
        @(negedge i_clk);
        while (beats_to_send.size() != 0 || in_valid || compare_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_set(input int value);
        logic [rgbf_pkg::DATA_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rgbf_pkg::ADDR_W'(int'(rgbf_pkg::REG_FADE_MS) * 4);
        pwdata  <= rgbf_pkg::DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mdl_fade = value & ((1 << rgbf_pkg::FADE_W) - 1);
        fade_settings++;
        @(posedge i_clk);
        psel    <= 1'b1;
        paddr   <= rgbf_pkg::ADDR_W'(int'(rgbf_pkg::REG_FADE_MS) * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== rgbf_pkg::DATA_W'(mdl_fade)) begin
            flag_error($sformatf("fade_ms readback: expected %0d, got %0h", mdl_fade, got));
        end
    endtask

    initial begin
        int  pick;
        int  fade;
        int  ticks;
        bit  first;
        mdl_fade    = 0;
        mdl_elapsed = 0;
        for (int i = 0; i < rgbf_pkg::NUM_CH; i++) begin
            mdl_target[i] = 0;
            mdl_start[i]  = 0;
            mdl_rate[i]   = 0;
        end
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        cfg_set(0);
        push_ticks(1);
        push_color(255, 0, 255);
        push_ticks(1);
        push_color(0, 255, 0);
        push_ticks(1);
        drain_all();
        cfg_set(1);
        push_color(255, 255, 255);
        push_ticks(3);
        drain_all();
        cfg_set(65535);
        push_color(0, 0, 0);
        push_ticks(1);
        drain_all();
        cfg_set(4);
        push_color(255, 128, 1);
        push_ticks(3);
        drain_all();
        cfg_set(200);
        push_ticks(2);
        drain_all();
        cfg_set(2);
        push_ticks(1);
        drain_all();
        cfg_set(3);
        push_color(0, 64, 255);
        push_ticks(3);
        drain_all();
        cfg_set(0);
        push_color(10, 20, 30);
        push_ticks(1);
        drain_all();
        cfg_set(50);
        push_ticks(2);

        first = 1'b1;
        while (beats_queued < 25 + RANDOM_BEATS) begin
            drain_all();
            pick = $urandom_range(0, 99);
            if (first) fade = 30;
            else if (pick < 8) fade = 0;
            else if (pick < 12) fade = 65535;
            else if (pick < 16) fade = 1;
            else if (pick < 22) fade = $urandom_range(41, 65534);
            else fade = $urandom_range(2, 40);
            cfg_set(fade);
            if (first) begin
                @(negedge i_clk);
                sink_pause_req = 1'b1;
                first = 1'b0;
            end
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 99) < 85) begin
                    push_color($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
                    if (fade == 0) ticks = $urandom_range(1, 4);
                    else if (fade > 40) ticks = $urandom_range(5, 40);
                    else ticks = fade + $urandom_range(0, 4);
                    push_ticks(ticks);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        push_beat(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255));
                    end
                end
            end
        end

        drain_all();
        if (compare_due.size() != 0) begin
            flag_error($sformatf("%0d expected results never arrived", compare_due.size()));
        end
        $display("tb: %0d beats sent (%0d ticks), %0d results checked, %0d fade settings",
                 beats_taken, ticks_taken, results_seen, fade_settings);
        $display("tb: %0d errors, including mismatches past the first ten", errors);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
